### hdl/wall_neighbor_tile_coder_core_assert.svh
// Assertion macros shared by the wall neighbour tile coder RTL.
// Expects clk_i and rst_ni in the scope of each use; define ASSERT_OFF to drop them.
`ifndef WALL_NEIGHBOR_TILE_CODER_CORE_ASSERT_SVH
`define WALL_NEIGHBOR_TILE_CODER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define WNTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define WNTC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define WNTC_ASSERT(lbl, prop, msg)
`define WNTC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### hdl/wntc_pkg.sv
// Shared types and constants of the wall neighbour tile coder.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none
package wntc_pkg;

  localparam logic [1:0] CFG_TILE_BASE  = 2'd0;
  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd2;

  localparam logic [3:0] SIDE_LEFT   = 4'h1;
  localparam logic [3:0] SIDE_RIGHT  = 4'h2;
  localparam logic [3:0] SIDE_TOP    = 4'h4;
  localparam logic [3:0] SIDE_BOTTOM = 4'h8;
  localparam logic [3:0] SIDE_NONE   = 4'h0;

  localparam logic [5:0] MAP_WIDTH_RESET  = 6'd32;
  localparam logic [5:0] MAP_HEIGHT_RESET = 6'd24;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_FLUSH = 2'b10
  } ctrl_state_e;

  typedef struct packed {
    logic take_cell;
    logic flush_mode;
    logic flush_load;
    logic clear_map;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic map_end;
    logic flush_last;
  } dp_sts_t;

endpackage
`default_nettype wire

### hdl/wntc_ctrl.sv
// Controller of the wall neighbour tile coder: run and final-row flush states.
// Depends on wntc_pkg and the assertion macro header.
`default_nettype none
`include "wall_neighbor_tile_coder_core_assert.svh"
module wntc_ctrl
  import wntc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_RUN: begin
        in_stall_o      = !sts_i.slot_free;
        cmd_o.take_cell = in_valid_i && sts_i.slot_free;
        if (cmd_o.take_cell && sts_i.map_end) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush_mode = 1'b1;
        if (sts_i.slot_free) begin
          cmd_o.flush_load = 1'b1;
          if (sts_i.flush_last) begin
            cmd_o.clear_map = 1'b1;
            state_d         = ST_RUN;
          end
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  `WNTC_ASSERT(a_map_end_flush, (cmd_o.take_cell && sts_i.map_end) |=> (state_q == ST_FLUSH), "map end did not start flush")
  `WNTC_ASSERT(a_flush_returns, (cmd_o.flush_load && sts_i.flush_last) |=> (state_q == ST_RUN), "flush did not return to run")

endmodule
`default_nettype wire

### hdl/wntc_dpath.sv
// Datapath of the wall neighbour tile coder: config, row bits, counters, tile
// evaluator and output beat register. Depends on wntc_pkg and the macro header.
`default_nettype none
`include "wall_neighbor_tile_coder_core_assert.svh"
module wntc_dpath
  import wntc_pkg::*;
#(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       wall_bit_i,
  input  wire logic       out_stall_i,
  output logic            out_valid_o,
  output logic [7:0]      tile_code_o,
  output logic            map_done_o,
  input  wire dp_cmd_t    cmd_i,
  output dp_sts_t         sts_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [3:0] base_hi_q;
  logic [5:0] width_q;
  logic [5:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_hi_q <= 4'h0;
      width_q   <= MAP_WIDTH_RESET;
      height_q  <= MAP_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TILE_BASE:  base_hi_q <= cfg_data_i[7:4];
        CFG_MAP_WIDTH:  width_q   <= cfg_data_i[5:0];
        CFG_MAP_HEIGHT: height_q  <= cfg_data_i[5:0];
        default: begin
        end
      endcase
    end
  end

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (width_q == 6'd0) begin
      w_eff = WW'(1);
    end else if (7'(width_q) > 7'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == 6'd0) begin
      h_eff = HW'(1);
    end else if (10'(height_q) > 10'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  logic [MAX_WIDTH-1:0] above_q, pend_q, cur_q, cur_with;
  logic [XW-1:0]        col_q, flush_idx_q;
  logic [RW-1:0]        row_q;
  logic                 row_end;

  assign cur_with       = cur_q | (MAX_WIDTH'(wall_bit_i) << col_q);
  assign row_end        = (7'(col_q) + 7'd1) >= 7'(w_eff);
  assign sts_o.map_end  = row_end && ((10'(row_q) + 10'd1) >= 10'(h_eff));
  assign sts_o.flush_last = (7'(flush_idx_q) + 7'd1) >= 7'(w_eff);

  logic [MAX_WIDTH-1:0] mid, up, down;
  logic [MAX_WIDTH:0]   mid_ext;
  logic [XW-1:0]        col;
  logic [EW-1:0]        col_ext;
  logic                 has_up, has_down;
  logic                 c_bit, l_bit, r_bit, u_bit, d_bit;
  logic [3:0]           mask;
  logic [7:0]           tile;

  always_comb begin
    if (cmd_i.flush_mode) begin
      mid      = cur_q;
      up       = pend_q;
      down     = '0;
      has_up   = (row_q != '0);
      has_down = 1'b0;
      col      = flush_idx_q;
    end else begin
      mid      = pend_q;
      up       = above_q;
      down     = cur_with;
      has_up   = (row_q > RW'(1));
      has_down = 1'b1;
      col      = col_q;
    end
    mid_ext = {1'b0, mid};
    col_ext = EW'(col);
    c_bit   = mid[col];
    l_bit   = (col == '0) ? 1'b0 : mid_ext[col_ext - EW'(1)];
    r_bit   = ((7'(col) + 7'd1) >= 7'(w_eff)) ? 1'b0 : mid_ext[col_ext + EW'(1)];
    u_bit   = has_up && up[col];
    d_bit   = has_down && down[col];
    mask    = (l_bit ? SIDE_NONE : SIDE_LEFT) | (r_bit ? SIDE_NONE : SIDE_RIGHT)
            | (u_bit ? SIDE_NONE : SIDE_TOP)  | (d_bit ? SIDE_NONE : SIDE_BOTTOM);
    tile    = c_bit ? {base_hi_q, mask} : {base_hi_q, SIDE_NONE};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q     <= '0;
      pend_q      <= '0;
      cur_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      flush_idx_q <= '0;
    end else if (cmd_i.clear_map) begin
      above_q     <= '0;
      pend_q      <= '0;
      cur_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      flush_idx_q <= '0;
    end else if (cmd_i.flush_load) begin
      flush_idx_q <= flush_idx_q + XW'(1);
    end else if (cmd_i.take_cell) begin
      if (sts_o.map_end) begin
        cur_q <= cur_with;
      end else if (row_end) begin
        above_q <= pend_q;
        pend_q  <= cur_with;
        cur_q   <= '0;
        col_q   <= '0;
        row_q   <= row_q + RW'(1);
      end else begin
        cur_q <= cur_with;
        col_q <= col_q + XW'(1);
      end
    end
  end

  logic       out_valid_q, out_done_q, out_load;
  logic [7:0] out_tile_q;

  assign out_load        = (cmd_i.take_cell && (row_q != '0)) || cmd_i.flush_load;
  assign sts_o.slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_tile_q <= tile;
      out_done_q <= cmd_i.flush_load && sts_o.flush_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tile_code_o = out_tile_q;
  assign map_done_o  = out_done_q;

  `WNTC_ASSERT_NEVER(a_no_overwrite, out_load && out_valid_q && out_stall_i, "stalled beat overwritten")
  `WNTC_ASSERT(a_flush_in_range, cmd_i.flush_mode |-> (7'(flush_idx_q) < 7'(w_eff)), "flush index past width")
  `WNTC_ASSERT(a_done_on_last, (cmd_i.flush_load && sts_o.flush_last) |=> (out_valid_q && out_done_q), "last tile not marked done")

endmodule
`default_nettype wire

### hdl/wall_neighbor_tile_coder_core.sv
// Wall neighbour tile coder, top level: joins controller and datapath.
// Depends on wntc_pkg, wntc_ctrl and wntc_dpath.
//
// Usage: feed the wall map one cell per beat on wall_bit_i, raster order,
// using in_valid_i / in_stall_o. Tile codes leave on tile_code_o with
// out_valid_o / out_stall_i; map_done_o marks the last tile of the map.
// Registers (tile_base, map_width, map_height) are written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while
// the block is idle, which the block does not enforce. Throughput: one input
// cell per cycle while the receiver keeps up and no flush runs. Each cell from
// the second row on yields the tile above it in the cycle after its beat. The
// last cell of the map starts a flush of the final row: map_width tiles, one
// a cycle while the receiver keeps up, with input stalled, counted by the
// flush index counter. Reset clears all row bits and counters and loads
// tile_base 0, width 32, height 24. When the receiver stalls, the pending
// beat holds in the output register and input stalls until it is taken.
`default_nettype none
module wall_neighbor_tile_coder_core
  import wntc_pkg::*;
#(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       wall_bit_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      tile_code_o,
  output logic            map_done_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  wntc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wntc_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .wall_bit_i  (wall_bit_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .tile_code_o (tile_code_o),
    .map_done_o  (map_done_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire
